>>> src/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared widths, codes and controller/datapath bundles of the first-fit
// bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  // Field widths
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 12;

  // Parameter defaults
  localparam int unsigned POOL_SIZE_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Register reset values
  localparam logic [IDX_W-1:0] LOWEST_RESET  = 12'd0;
  localparam logic [IDX_W-1:0] HIGHEST_RESET = 12'd4095;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 1'd1;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_MARK  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

  typedef enum logic [1:0] {
    RES_HIT,
    RES_NO_FREE,
    RES_RANGE
  } res_e;

  // Controller -> datapath
  typedef struct packed {
    logic load_req;   // capture accepted request
    logic setup;      // start word from reciprocal divide
    logic rd_base;    // first map read, base index multiply
    logic advance;    // step to next map word
    logic commit;     // write back word with the claimed bit set
    logic clr_step;   // clearing pass write
    logic load_res;   // load output register
    res_e res_kind;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic req_mark;
    logic reject;     // out-of-range mark or empty scan window
    logic hit;
    logic last_word;
  } ctrl_sts_t;

endpackage

>>> src/bffa_if.sv
// ----------------------------------------------------------------------------
// bffa_if
// Valid/ready channels for requests and results of the allocator.
// ----------------------------------------------------------------------------
interface bffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [bffa_pkg::IDX_W-1:0]  mark_index;

  modport source (output valid, output req_type, output mark_index, input ready);
  modport sink   (input valid, input req_type, input mark_index, output ready);
endinterface

interface bffa_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bffa_pkg::IDX_W-1:0]  granted_index;
  logic [bffa_pkg::STAT_W-1:0] status;

  modport source (output valid, output granted_index, output status, input ready);
  modport sink   (input valid, input granted_index, input status, output ready);
endinterface

>>> src/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bffa_datapath.sv
// ----------------------------------------------------------------------------
// bffa_datapath
// Config registers, request capture, used-bit map RAM, per-word first-free
// search and result register.
// ----------------------------------------------------------------------------
module bffa_datapath #(
  parameter int unsigned POOL_SIZE = bffa_pkg::POOL_SIZE_DEF,
  parameter int unsigned WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bffa_pkg::ctrl_cmd_t              cmd_i,
  output bffa_pkg::ctrl_sts_t              sts_o,
  input  logic                             cfg_we_i,
  input  logic [bffa_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bffa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             req_type_i,
  input  logic [bffa_pkg::IDX_W-1:0]       mark_index_i,
  output logic [bffa_pkg::IDX_W-1:0]       granted_index_o,
  output logic [bffa_pkg::STAT_W-1:0]      status_o
);

  localparam int unsigned IW   = bffa_pkg::IDX_W;
  localparam int unsigned XW   = IW + 1;                 // index with carry room
  localparam int unsigned SPAN = 1 << IW;                // indexes reachable
  // Entries beyond the index field's reach are never touched, so no storage.
  localparam int unsigned POOL_LIMIT = (POOL_SIZE < SPAN) ? POOL_SIZE : SPAN;
  localparam int unsigned MAP_DEPTH  = (POOL_LIMIT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW   = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned BW   = $clog2(WORD_BITS);
  // index / WORD_BITS as multiply by rounded-up reciprocal, exact below 2^IW
  localparam int unsigned SH     = IW + BW;
  localparam int unsigned RECIP  = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned RECIP_W = IW + 1;
  localparam int unsigned PROD_W = IW + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'(RECIP);
  localparam logic [XW-1:0]      LIMIT_C  = XW'(POOL_LIMIT);
  localparam logic [IW-1:0]      TOP_MAX  = IW'(POOL_LIMIT - 1);
  localparam logic [AW-1:0]      LAST_ADR = AW'(MAP_DEPTH - 1);

  logic [IW-1:0]     lo_q, hi_q, top_q, top_d, mark_q;
  logic              req_mark_q;
  logic [AW-1:0]     w_q, w_d, w_inc, raddr;
  logic [XW-1:0]     base_q, base_d;
  logic [IW-1:0]     granted_q, granted_d;
  logic [bffa_pkg::STAT_W-1:0] status_q, status_d;

  logic [IW-1:0]        div_src;
  logic [PROD_W-1:0]    prod;
  logic [WORD_BITS-1:0] rdata, cand, mark_bit, first_free, set_mask;
  logic [BW-1:0]        free_bit;
  logic [XW:0]          next_base;
  logic [IW-1:0]        found_idx;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= bffa_pkg::LOWEST_RESET;
      hi_q <= bffa_pkg::HIGHEST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bffa_pkg::CFG_LOWEST:  lo_q <= cfg_data_i;
        bffa_pkg::CFG_HIGHEST: hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign top_d = (hi_q > TOP_MAX) ? TOP_MAX : hi_q;

  // Start word: lowest index for a scan, the index itself for a mark
  assign div_src = req_mark_q ? mark_q : lo_q;
  assign prod    = PROD_W'(div_src) * PROD_W'(RECIP_C);
  assign w_inc   = w_q + AW'(1);

  always_comb begin
    w_d = w_q;
    if (cmd_i.setup) begin
      w_d = AW'(prod >> SH);
    end else if (cmd_i.clr_step || cmd_i.advance) begin
      w_d = w_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
    end else begin
      w_q <= w_d;
    end
  end

  assign base_d = cmd_i.rd_base ? XW'(w_q * WORD_BITS) :
                  XW'(base_q + XW'(WORD_BITS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_mark_q <= (req_type_i == bffa_pkg::REQ_MARK);
      mark_q     <= mark_index_i;
      top_q      <= top_d;
    end
    if (cmd_i.rd_base || cmd_i.advance) begin
      base_q <= base_d;
    end
    if (cmd_i.load_res) begin
      granted_q <= granted_d;
      status_q  <= status_d;
    end
  end

  // Used-bit map
  assign raddr = cmd_i.advance ? w_inc : w_q;
  assign we    = cmd_i.clr_step || cmd_i.commit;
  assign wdata = cmd_i.clr_step ? '0 : (rdata | set_mask);

  bffa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (w_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_base || cmd_i.advance),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Per-bit window check against absolute index of each bit
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      cand[j]     = !rdata[j]
                    && (XW'(base_q + XW'(j)) >= XW'(lo_q))
                    && (XW'(base_q + XW'(j)) <= XW'(top_q));
      mark_bit[j] = (XW'(base_q + XW'(j)) == XW'(mark_q));
    end
  end

  assign first_free = cand & (~cand + WORD_BITS'(1));

  always_comb begin
    free_bit = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      free_bit = free_bit | (first_free[j] ? BW'(j) : BW'(0));
    end
  end

  assign set_mask  = req_mark_q ? mark_bit : first_free;
  assign found_idx = IW'(base_q + XW'(free_bit));
  assign next_base = (XW+1)'(base_q) + (XW+1)'(WORD_BITS);

  always_comb begin
    granted_d = '0;
    status_d  = bffa_pkg::ST_OK;
    case (cmd_i.res_kind)
      bffa_pkg::RES_HIT:     granted_d = req_mark_q ? mark_q : found_idx;
      bffa_pkg::RES_NO_FREE: status_d  = bffa_pkg::ST_NO_FREE;
      bffa_pkg::RES_RANGE:   status_d  = bffa_pkg::ST_RANGE;
      default:               status_d  = bffa_pkg::ST_OK;
    endcase
  end

  assign sts_o.clr_last  = (w_q == LAST_ADR);
  assign sts_o.req_mark  = req_mark_q;
  assign sts_o.reject    = req_mark_q ? (XW'(mark_q) >= LIMIT_C) : (lo_q > top_q);
  assign sts_o.hit       = req_mark_q || (|cand);
  assign sts_o.last_word = next_base > (XW+1)'(top_q);

  assign granted_index_o = granted_q;
  assign status_o        = status_q;

  a_commit_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> $onehot(set_mask))
    else $error("map write-back does not set exactly one bit");

  a_advance_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> !sts_o.last_word && (w_inc != '0))
    else $error("scan stepped past the window's last word");

endmodule

>>> src/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer: clearing pass, request setup, word-by-word scan, result hand-off.
// ----------------------------------------------------------------------------
module bffa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bffa_pkg::ctrl_sts_t sts_i,
  output bffa_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_BASE,
    ST_EXAM
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_kind = bffa_pkg::RES_HIT;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (!sts_i.reject) begin
          state_d = ST_BASE;
        end else if (slot_free) begin
          cmd_o.load_res = 1'b1;
          cmd_o.res_kind = sts_i.req_mark ? bffa_pkg::RES_RANGE : bffa_pkg::RES_NO_FREE;
          state_d        = ST_IDLE;
        end
      end
      ST_BASE: begin
        cmd_o.rd_base = 1'b1;
        state_d       = ST_EXAM;
      end
      ST_EXAM: begin
        if (slot_free) begin
          if (sts_i.hit) begin
            cmd_o.commit   = 1'b1;
            cmd_o.load_res = 1'b1;
            state_d        = ST_IDLE;
          end else if (sts_i.last_word) begin
            cmd_o.load_res = 1'b1;
            cmd_o.res_kind = bffa_pkg::RES_NO_FREE;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_res || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_res |-> slot_free)
    else $error("result loaded over an untaken result");

  a_accept_to_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_SETUP))
    else $error("accepted request did not enter setup");

  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !cmd_o.clr_step && !cmd_o.advance)
    else $error("map write-back overlaps another map operation");

endmodule

>>> src/bitmap_first_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_top
// First-fit allocator over a used-bit map of numbered pool entries.
// ----------------------------------------------------------------------------
// The block keeps one used bit per pool entry in a RAM of WORD_BITS-wide
// words, covering min(POOL_SIZE, 4096) entries. After reset a clearing pass
// writes zero to every map word, one word per cycle; no request is taken
// during it, config writes are. A request is processed one at a time: the
// accept step, a setup step (start word from a reciprocal multiply), a step
// to issue the first map read and form the word's base index, then an
// examine step per map word, limited by the single RAM read port. A mark
// examines only the word that holds its index; an allocate scans up to the
// window's last word. A mark past the pool or an empty scan window (lowest
// above the clamped highest) is answered from the setup step. Each request
// yields one result transfer; a finished result sits in an output register,
// so the next request is accepted while it waits, and the scan pauses while
// an untaken result is held there. Config registers must only be written
// while no request is outstanding.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_top #(
  parameter int unsigned POOL_SIZE = bffa_pkg::POOL_SIZE_DEF,
  parameter int unsigned WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Config write port: index 0 lowest_index, 1 highest_index
  input  logic                            cfg_we_i,
  input  logic [bffa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bffa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request and result channels
  bffa_req_if.sink                        req_i,
  bffa_rsp_if.source                      rsp_o
);

  bffa_pkg::ctrl_cmd_t cmd;
  bffa_pkg::ctrl_sts_t sts;

  // Sequencer: owns handshake state and the result-valid flag
  bffa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: config, map RAM, word search, result payload
  bffa_datapath #(
    .POOL_SIZE (POOL_SIZE),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_i.req_type),
    .mark_index_i    (req_i.mark_index),
    .granted_index_o (rsp_o.granted_index),
    .status_o        (rsp_o.status)
  );

endmodule
